// ----- design/per_label_volume_length_stats_top_defines.svh -----
// assertion macros for the label statistics block
`ifndef PER_LABEL_VOLUME_LENGTH_STATS_TOP_DEFINES_SVH
`define PER_LABEL_VOLUME_LENGTH_STATS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PLS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PLS_ASSERT(lbl, cond, msg)
`define PLS_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

// ----- design/pls_pkg.sv -----
`timescale 1ns / 1ps
package pls_pkg;
  localparam int NumLabels  = 256;
  localparam int LabelWidth = 8;
  localparam int GenWidth   = 8;
  localparam int CoordWidth = 10;
  localparam int CountWidth = 24;
  localparam int LenWidth   = 32;
  localparam int VolWidth   = 56;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 32;
  localparam int IdxWidth   = $clog2(NumLabels);
  // scaled delta is coord+16 bits, square twice that, sum two more
  localparam int DeltaWidth = CoordWidth + 16;
  localparam int SumWidth   = 2 * DeltaWidth + 2;
  localparam int RootWidth  = (SumWidth + 1) / 2;
  localparam int GenReportLimit = 10;

  localparam logic [1:0] OP_VOXEL = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CfgIdxWidth-1:0] REG_SPACING_X = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_SPACING_Y = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SPACING_Z = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_VOXEL_VOL = 2'd3;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [LabelWidth-1:0] label;
    logic [GenWidth-1:0]   generation;
    logic [CoordWidth-1:0] point_x;
    logic [CoordWidth-1:0] point_y;
    logic [CoordWidth-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [LabelWidth-1:0] record_label;
    logic                  reportable;
    logic [GenWidth-1:0]   record_generation;
    logic [CountWidth-1:0] voxel_count;
    logic [VolWidth-1:0]   segment_volume;
    logic [LenWidth-1:0]   segment_length;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [GenWidth-1:0]   gen;
    logic [CountWidth-1:0] count;
    logic [LenWidth-1:0]   len;
  } entry_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic                wr;
    logic [IdxWidth-1:0] addr;
    entry_t              data;
  } mem_req_t;
endpackage

// ----- design/pls_table_ram.sv -----
`timescale 1ns / 1ps
module pls_table_ram
  import pls_pkg::*;
(
  input  logic     clk,
  input  logic     rd,
  input  logic [IdxWidth-1:0] rd_addr,
  input  mem_req_t wreq,
  output entry_t   rd_data
);
  entry_t mem [NumLabels];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (wreq.wr) begin
      mem[wreq.addr] <= wreq.data;
    end
    if (rd) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- design/pls_isqrt.sv -----
`timescale 1ns / 1ps
module pls_isqrt
  import pls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SumWidth-1:0]  value,
  output logic                 done,
  output logic [RootWidth-1:0] root
);
  localparam int StepWidth = $clog2(RootWidth + 1);
  logic [SumWidth-1:0]  rad;
  logic [RootWidth:0]   rem;
  logic [RootWidth-1:0] res;
  logic [StepWidth-1:0] steps;
  logic                 busy;
  logic [RootWidth+2:0] part;
  logic [RootWidth+2:0] trial;

  // next two radicand bits onto the remainder, and the trial subtrahend
  always_comb begin
    part  = {rem, rad[SumWidth-1 -: 2]};
    trial = {1'b0, res, 2'b01};
  end

  // one result bit per cycle, restoring method
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rad   <= value;
        rem   <= '0;
        res   <= '0;
        steps <= StepWidth'(RootWidth);
      end else if (busy) begin
        if (part >= trial) begin
          rem <= (RootWidth + 1)'(part - trial);
          res <= {res[RootWidth-2:0], 1'b1};
        end else begin
          rem <= (RootWidth + 1)'(part);
          res <= {res[RootWidth-2:0], 1'b0};
        end
        rad   <= {rad[SumWidth-3:0], 2'b00};
        steps <= steps - 1'b1;
        if (steps == StepWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign root = res;
endmodule

// ----- design/per_label_volume_length_stats_top.sv -----
`timescale 1ns / 1ps
// Per-label statistics engine. A voxel request is a memory read, modify and write back; a
// read request scales the count by the voxel volume. After every table write, input is held
// off until the write is in so that the next request never reads a stale entry. A tree point
// request waits on the bit-serial square root (one root bit per cycle, 27 bits). After reset
// a clearing pass sweeps all 256 label table entries before the first request is taken.
// The read result waits in an output register until it is taken.
`include "per_label_volume_length_stats_top_defines.svh"
module per_label_volume_length_stats_top
  import pls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SQRT, S_WAIT, S_MUL, S_OUT
  } state_t;
  state_t state;

  logic [15:0] spacing_x, spacing_y, spacing_z;
  logic [31:0] voxel_volume;
  logic [LabelWidth-1:0] last_label;
  logic [CoordWidth-1:0] last_x, last_y, last_z;
  logic [IdxWidth:0] clr_cnt;
  in_item_t req;
  mem_req_t wreq;
  entry_t   rd_data;
  logic     sq_start, sq_done;
  logic [RootWidth-1:0] root;
  logic [SumWidth-1:0]  sum;
  logic [DeltaWidth-1:0] dx, dy, dz;
  logic [VolWidth-1:0] vol;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_x <= 16'd256;
      spacing_y <= 16'd256;
      spacing_z <= 16'd256;
      voxel_volume <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACING_X: spacing_x <= cfg_data[15:0];
        REG_SPACING_Y: spacing_y <= cfg_data[15:0];
        REG_SPACING_Z: spacing_z <= cfg_data[15:0];
        REG_VOXEL_VOL: voxel_volume <= cfg_data;
        default: ;
      endcase
    end
  end

  logic label_ok;
  assign label_ok = (32'(req.label) < NumLabels);

  pls_table_ram u_ram (
    .clk(clk), .rd(in_valid && !in_stall), .rd_addr(IdxWidth'(in_data.label)),
    .wreq(wreq), .rd_data(rd_data)
  );

  // unscaled deltas from the previous point (moved to the current point on a label change)
  logic [CoordWidth-1:0] px, py, pz;
  assign px = (req.label != last_label) ? req.point_x : last_x;
  assign py = (req.label != last_label) ? req.point_y : last_y;
  assign pz = (req.label != last_label) ? req.point_z : last_z;
  logic [CoordWidth-1:0] ax, ay, az;
  assign ax = (req.point_x >= px) ? req.point_x - px : px - req.point_x;
  assign ay = (req.point_y >= py) ? req.point_y - py : py - req.point_y;
  assign az = (req.point_z >= pz) ? req.point_z - pz : pz - req.point_z;

  pls_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sum), .done(sq_done), .root(root)
  );

  logic [LenWidth:0] acc;
  assign acc = {1'b0, rd_data.len} + (LenWidth + 1)'(root);

  // sequencer
  always_ff @(posedge clk) begin
    sq_start <= 1'b0;
    wreq.wr  <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      last_label <= '0;
      last_x <= '0;
      last_y <= '0;
      last_z <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          wreq.wr   <= 1'b1;
          wreq.addr <= clr_cnt[IdxWidth-1:0];
          wreq.data <= '0;
          clr_cnt   <= clr_cnt + 1'b1;
          if (clr_cnt == (IdxWidth + 1)'(NumLabels - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          // hold off while the previous write back is still going into the table
          if (in_valid && !wreq.wr) begin
            req <= in_data;
            state <= S_READ;
          end
        end
        S_READ: begin
          wreq.addr <= IdxWidth'(req.label);
          state <= S_IDLE;
          case (req.opcode)
            OP_VOXEL: begin
              if (req.label != '0 && label_ok && rd_data.count != '1) begin
                wreq.wr <= 1'b1;
                wreq.data <= '{gen: rd_data.gen, count: rd_data.count + 1'b1,
                               len: rd_data.len};
              end
            end
            OP_POINT: begin
              wreq.data <= rd_data;
              dx <= DeltaWidth'(ax) * DeltaWidth'(spacing_x);
              dy <= DeltaWidth'(ay) * DeltaWidth'(spacing_y);
              dz <= DeltaWidth'(az) * DeltaWidth'(spacing_z);
              state <= S_SQRT;
            end
            OP_READ: begin
              vol <= VolWidth'(rd_data.count) * VolWidth'(voxel_volume);
              state <= S_MUL;
            end
            default: ;
          endcase
        end
        S_SQRT: begin
          sum <= SumWidth'(dx) * SumWidth'(dx) + SumWidth'(dy) * SumWidth'(dy)
               + SumWidth'(dz) * SumWidth'(dz);
          sq_start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (sq_done) begin
            if (label_ok) begin
              wreq.wr <= 1'b1;
              wreq.data.gen <= req.generation;
              wreq.data.len <= acc[LenWidth] ? '1 : acc[LenWidth-1:0];
            end
            last_label <= req.label;
            last_x <= req.point_x;
            last_y <= req.point_y;
            last_z <= req.point_z;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          out_valid <= 1'b1;
          out_data.record_label <= req.label;
          out_data.reportable <= label_ok && rd_data.gen >= GenWidth'(1)
                                 && rd_data.gen < GenWidth'(GenReportLimit);
          out_data.record_generation <= label_ok ? rd_data.gen : '0;
          out_data.voxel_count <= label_ok ? rd_data.count : '0;
          out_data.segment_volume <= label_ok ? vol : '0;
          out_data.segment_length <= label_ok ? rd_data.len : '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE) || wreq.wr;

  `PLS_ASSERT(a_out_only_read, !out_valid || req.opcode == OP_READ, "result without read")
  `PLS_ASSERT(a_no_take_busy, !(out_valid && !in_stall), "request taken with result pending")
  `PLS_ASSERT_IMP(a_sqrt_start, sq_start, state == S_WAIT, "root started outside wait")
endmodule
